// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Payload structs, round constants, initial hash values and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Byte source selects for the buffer write.
	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} byte_src_t;

	typedef struct packed {
		logic      wr_en;      // write one byte into the buffer
		byte_src_t src;
		logic [7:0] data;
		logic      count_en;   // count a message byte
		logic      start;      // start a compression of the buffer
		logic      rearm;      // reload initial hash, clear counters
	} dp_cmd_t;

	typedef struct packed {
		logic       busy;      // compression running
		logic [5:0] fill;
	} dp_status_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== src/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window filled byte by byte, length counter, one round per
// cycle and the chaining words.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_pkg::dp_cmd_t    cmd,
	input  logic [2:0]          rd_index,
	output logic [31:0]         rd_word,
	output sha_pkg::dp_status_t status
);

	logic [5:0]  fill_q;
	logic [60:0] msg_bytes_q;
	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  round_q;
	logic        busy_q;
	logic [63:0] bit_len;
	logic [7:0]  wr_byte;
	logic [31:0] s0, s1, sig0, sig1, ch, maj, t1, t2, w_new;

	assign bit_len = {msg_bytes_q, 3'b000};

	// Length bytes go out big-endian from buffer position 56.
	always_comb begin
		case (cmd.src)
			sha_pkg::SRC_DATA: wr_byte = cmd.data;
			sha_pkg::SRC_PAD:  wr_byte = sha_pkg::PAD_BYTE;
			sha_pkg::SRC_ZERO: wr_byte = 8'h00;
			default:           wr_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
		endcase
	end

	assign s0    = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1    = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19)
		^ (w_q[14] >> 10);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign sig1  = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
		^ sha_pkg::rotr(v_q[4], 25);
	assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1    = v_q[7] + sig1 + ch + sha_pkg::ROUND_K[round_q] + w_q[0];
	assign sig0  = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
		^ sha_pkg::rotr(v_q[0], 22);
	assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2    = sig0 + maj;

	always_ff @(posedge clk) begin
		// Bytes land big-endian straight in the schedule window, which shifts
		// during the rounds and is fully rewritten before the next block.
		if (cmd.wr_en) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			msg_bytes_q <= '0;
			busy_q      <= 1'b0;
			round_q     <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha_pkg::INIT_HASH[i];
			end
		end else begin
			if (cmd.wr_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count_en) begin
				msg_bytes_q <= msg_bytes_q + 61'd1;
			end
			if (cmd.start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
			// The feed-forward lands together with the last round.
			if (cmd.rearm) begin
				msg_bytes_q <= '0;
				fill_q      <= '0;
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= sha_pkg::INIT_HASH[i];
				end
			end else if (busy_q && round_q == 6'd63) begin
				hash_q[0] <= hash_q[0] + t1 + t2;
				hash_q[1] <= hash_q[1] + v_q[0];
				hash_q[2] <= hash_q[2] + v_q[1];
				hash_q[3] <= hash_q[3] + v_q[2];
				hash_q[4] <= hash_q[4] + v_q[3] + t1;
				hash_q[5] <= hash_q[5] + v_q[4];
				hash_q[6] <= hash_q[6] + v_q[5];
				hash_q[7] <= hash_q[7] + v_q[6];
			end
		end
	end

	assign rd_word     = hash_q[rd_index];
	assign status.busy = busy_q;
	assign status.fill = fill_q;

endmodule

// ===== src/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sha_pkg::out_item_t  out_data,
	output sha_pkg::dp_cmd_t    cmd,
	output logic [2:0]          rd_index,
	input  logic [31:0]         rd_word,
	input  sha_pkg::dp_status_t status
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_ZERO = 6'b000100,
		ST_LEN  = 6'b001000,
		ST_WAIT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] idx_q;
	logic       fin_q;      // registered copy of cmd.start
	logic       accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || status.busy;
	assign rd_index = idx_q;

	always_comb begin
		cmd          = '0;
		cmd.src      = sha_pkg::SRC_DATA;
		cmd.data     = in_data.data_byte;
		state_d      = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.command == sha_pkg::CMD_ABSORB) begin
						cmd.wr_en    = 1'b1;
						cmd.count_en = 1'b1;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (!status.busy) begin
					cmd.wr_en = 1'b1;
					cmd.src   = sha_pkg::SRC_PAD;
					state_d   = (status.fill == sha_pkg::LEN_POS - 6'd1) ? ST_LEN : ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (!status.busy) begin
					if (status.fill == sha_pkg::LEN_POS) begin
						state_d = ST_LEN;
					end else begin
						cmd.wr_en = 1'b1;
						cmd.src   = sha_pkg::SRC_ZERO;
					end
				end
			end
			ST_LEN: begin
				if (!status.busy) begin
					cmd.wr_en = 1'b1;
					cmd.src   = sha_pkg::SRC_LEN;
					if (status.fill == 6'd63) begin
						state_d = ST_WAIT;
					end
				end
			end
			ST_WAIT: begin
				if (!status.busy && !fin_q) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall && idx_q == 3'd7) begin
					cmd.rearm = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// A write of the 64th byte starts a compression in the same cycle.
		cmd.start = cmd.wr_en && (status.fill == 6'd63);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// fin_q is cmd.start registered; it rises together with busy.
			fin_q   <= cmd.start;
			if (state_q == ST_OUT && !out_stall) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign out_valid            = (state_q == ST_OUT);
	assign out_data.digest_word = rd_word;
	assign out_data.word_index  = idx_q;
	assign out_data.last_word   = (idx_q == 3'd7);

endmodule

// ===== src/sha256_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Top level: controller and datapath.
// ----------------------------------------------------------------------------
// Usage: each input request carries one command. An absorb request adds one
// message byte; a finish request pads the message, runs the last one or two
// compressions and then offers the eight digest words, H0 first, on the
// output channel, last_word marking the eighth.
// Rate: an absorb request is taken in one cycle, except that the 64th byte
// of a block starts a compression of 64 rounds (one round per cycle), during
// which no request is taken.
// A finish writes the pad, zero and length bytes one per cycle while no
// compression runs, up to the end of the block, and runs 64 rounds for each
// compression; the first digest word is offered once the last compression
// has finished.
// Then one cycle per digest word while not stalled.
// When the receiver stalls, the current word holds until taken.
// Reset puts the initial hash values in place and clears the byte counters;
// the block is ready for a request as soon as reset is released.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sha_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output sha_pkg::out_item_t out_data
);

	sha_pkg::dp_cmd_t    cmd;
	sha_pkg::dp_status_t status;
	logic [2:0]          rd_index;
	logic [31:0]         rd_word;

	sha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cmd      (cmd),
		.rd_index (rd_index),
		.rd_word  (rd_word),
		.status   (status)
	);

	sha_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_index(rd_index),
		.rd_word (rd_word),
		.status  (status)
	);

endmodule
